// File: rtl/dpfrc_pkg.sv
// Package for the dedup packet FIFO with range count.
// Holds sizes, command codes, payload structs and the controller state type.
// No dependencies.
package dpfrc_pkg;

  localparam int CAPACITY = 64;
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;   // slot index width
  localparam int CW = $clog2(CAPACITY + 1);                    // occupancy width
  localparam int SW = IW + 1;                                  // slot sum width
  localparam int LIM_W = 7;                                    // memory_limit width
  localparam int EW = (CW > LIM_W) ? CW : LIM_W;               // limit compare width
  localparam int CNT_W = 7;                                    // match_count width
  localparam int ENTRY_W = 64;

  localparam logic [LIM_W-1:0] LIMIT_RESET = LIM_W'(64);
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_FWD   = 2'd1,
    CMD_COUNT = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] src_id;
    logic [15:0] dest_id;
    logic [31:0] stamp;
    logic [31:0] range_start;
    logic [31:0] range_end;
  } req_t;

  typedef struct packed {
    logic             accepted;
    logic             dropped_oldest;
    logic             fwd_valid;
    logic [15:0]      out_src;
    logic [15:0]      out_dest;
    logic [31:0]      out_stamp;
    logic [CNT_W-1:0] match_count;
  } rsp_t;

  // controller -> scan unit
  typedef struct packed {
    logic clear;
    logic hit_valid;
  } scan_ctl_t;

  // scan unit -> controller
  typedef struct packed {
    logic               dup;
    logic [CNT_W-1:0]   count;
    logic [ENTRY_W-1:0] word;
  } scan_stat_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

endpackage

// File: rtl/dpfrc_ram.sv
// Generic single-write, single-read synchronous RAM, registered read data.
// No dependencies.
module dpfrc_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 64,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/dpfrc_scan.sv
// Per-entry compare unit: duplicate flag, range match count, last word read.
// Depends on dpfrc_pkg.
module dpfrc_scan
  import dpfrc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  scan_ctl_t          ctl,
  input  req_t               key,
  input  logic [ENTRY_W-1:0] rd_data,
  output scan_stat_t         stat
);

  logic               dup;
  logic [CNT_W-1:0]   count;
  logic [ENTRY_W-1:0] word;
  logic               same;
  logic               in_range;

  assign same = (rd_data == {key.src_id, key.dest_id, key.stamp});
  assign in_range = (rd_data[47:32] == key.dest_id) &&
                    (rd_data[31:0] >= key.range_start) &&
                    (rd_data[31:0] <= key.range_end);

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      dup   <= 1'b0;
      count <= '0;
    end else if (ctl.hit_valid) begin
      if (same) begin
        dup <= 1'b1;
      end
      if (in_range && count != CNT_MAX) begin
        count <= count + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.hit_valid) begin
      word <= rd_data;
    end
  end

  assign stat = '{dup: dup, count: count, word: word};

endmodule

// File: rtl/dedup_packet_fifo_with_range_count_unit.sv
// Top level of the dedup packet FIFO with range count.
// Ring buffer controller, occupancy/head state and result register.
// Depends on dpfrc_pkg, dpfrc_ram, dpfrc_scan.
//
//  channel | signals                      | payload
//  --------+------------------------------+-----------------------------
//  request | req_valid / req_ready / req  | req_t: cmd, ids, stamp, range
//  result  | rsp_valid / rsp_ready / rsp  | rsp_t: flags, packet, count
//  config  | cfg_valid / cfg_ready / cfg_data | memory_limit, 7 bits
//
// Operation: one request at a time. Add and count walk every held entry
// through the single RAM read port, one entry a cycle; forward reads
// only the oldest entry, none on an empty store; an unused cmd reads none.
// Reset: occupancy and head clear, memory_limit loads 64; RAM not cleared.
// Stalls: a finished result waits in S_DONE until the result register is
// free; the state commit and RAM write happen with that load.
// Config is always ready and is written at any transfer.
module dedup_packet_fifo_with_range_count_unit
  import dpfrc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  req_t             req,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output rsp_t             rsp,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [LIM_W-1:0] cfg_data
);

  state_t state, state_next;

  logic [IW-1:0]    head;
  logic [CW-1:0]    occ;
  logic [CW-1:0]    k;
  logic [IW-1:0]    ptr;
  logic             rd_pend;
  logic [LIM_W-1:0] mem_limit;
  req_t             req_q;

  logic             accept;
  logic             issue;
  logic             commit;
  logic [CW-1:0]    scan_len;
  logic [EW-1:0]    eff_limit;
  logic             evict;
  logic [SW-1:0]    tail_sum;
  logic [IW-1:0]    tail;
  logic             add_ok;
  logic             fwd_ok;
  rsp_t             rsp_next;
  logic [ENTRY_W-1:0] rd_data;

  scan_ctl_t  sctl;
  scan_stat_t sstat;

  function automatic logic [IW-1:0] idx_inc(input logic [IW-1:0] idx);
    idx_inc = (idx == IW'(CAPACITY - 1)) ? '0 : idx + IW'(1);
  endfunction

  assign cfg_ready = 1'b1;
  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;

  // entries walked: all held for add/count, the oldest for forward
  always_comb begin
    case (req_q.cmd)
      CMD_ADD, CMD_COUNT: scan_len = occ;
      CMD_FWD:            scan_len = (occ != '0) ? CW'(1) : '0;
      default:            scan_len = '0;
    endcase
  end

  // limit 0 acts as 1, above capacity saturates
  always_comb begin
    if (mem_limit == '0) begin
      eff_limit = EW'(1);
    end else if (EW'(mem_limit) > EW'(CAPACITY)) begin
      eff_limit = EW'(CAPACITY);
    end else begin
      eff_limit = EW'(mem_limit);
    end
  end

  assign evict = (EW'(occ) >= eff_limit);

  // append slot = head + occ, modulo capacity (the evicted slot only when the store is full)
  assign tail_sum = SW'(head) + SW'(occ);
  assign tail = (tail_sum >= SW'(CAPACITY)) ? IW'(tail_sum - SW'(CAPACITY))
                                            : IW'(tail_sum);

  assign add_ok = (req_q.cmd == CMD_ADD) && !sstat.dup;
  assign fwd_ok = (req_q.cmd == CMD_FWD) && (occ != '0);

  always_comb begin
    rsp_next = '0;
    case (req_q.cmd)
      CMD_ADD: begin
        rsp_next.accepted       = !sstat.dup;
        rsp_next.dropped_oldest = !sstat.dup && evict;
      end
      CMD_FWD: begin
        if (occ != '0) begin
          rsp_next.fwd_valid = 1'b1;
          rsp_next.out_src   = sstat.word[63:48];
          rsp_next.out_dest  = sstat.word[47:32];
          rsp_next.out_stamp = sstat.word[31:0];
        end
      end
      CMD_COUNT: rsp_next.match_count = sstat.count;
      default: ;
    endcase
  end

  // controller: walk reads, wait for last data, then commit with result load
  always_comb begin
    state_next = state;
    issue      = 1'b0;
    commit     = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        issue = (k < scan_len);
        if (!issue && !rd_pend) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!rsp_valid || rsp_ready) begin
          commit     = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign sctl = '{clear: accept, hit_valid: rd_pend};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      occ       <= '0;
      k         <= '0;
      rd_pend   <= 1'b0;
      mem_limit <= LIMIT_RESET;
      rsp_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        mem_limit <= cfg_data;
      end
      rd_pend <= issue;
      if (accept) begin
        k <= '0;
      end else if (issue) begin
        k <= k + CW'(1);
      end
      if (commit) begin
        if (add_ok) begin
          if (evict) begin
            head <= idx_inc(head);
          end else begin
            occ <= occ + CW'(1);
          end
        end else if (fwd_ok) begin
          head <= idx_inc(head);
          occ  <= occ - CW'(1);
        end
      end
      if (commit) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= req;
      ptr   <= head;
    end else if (issue) begin
      ptr <= idx_inc(ptr);
    end
    if (commit) begin
      rsp <= rsp_next;
    end
  end

  dpfrc_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (ENTRY_W),
    .AW    (IW)
  ) u_ram (
    .clk   (clk),
    .we    (commit && add_ok),
    .waddr (tail),
    .wdata ({req_q.src_id, req_q.dest_id, req_q.stamp}),
    .re    (issue),
    .raddr (ptr),
    .rdata (rd_data)
  );

  dpfrc_scan u_scan (
    .clk     (clk),
    .rst     (rst),
    .ctl     (sctl),
    .key     (req_q),
    .rd_data (rd_data),
    .stat    (sstat)
  );

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= CW'(CAPACITY))
    else $error("occupancy above capacity");

  a_pend_in_scan: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> (state == S_SCAN))
    else $error("read data returned outside scan");

  a_fwd_pop: assert property (@(posedge clk) disable iff (rst)
    (commit && fwd_ok) |=> (occ == $past(occ) - CW'(1)))
    else $error("forward did not pop one entry");

  a_drop_needs_accept: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.dropped_oldest) |-> (rsp.accepted && !rsp.fwd_valid))
    else $error("drop flagged without accepted add");

endmodule

// File: verif/tb_dedup_packet_fifo_with_range_count_unit.sv
`timescale 1ns / 100ps
// Testbench for dedup_packet_fifo_with_range_count_unit: directed and random traffic.
// Carries its own shadow of the packet store and checks every result transfer in order.
// Depends on dpfrc_pkg and the unit under test.
module tb_dedup_packet_fifo_with_range_count_unit
  import dpfrc_pkg::*;
();

  localparam int MAX_CYCLES   = 1000000;
  // Worst-case request latency: full store walk plus pipeline overhead.
  localparam int DRAIN_CYCLES = CAPACITY + 16;

  // ---------------------------------------------------------------------------
  // Shadow of the packet store. Held packets are kept oldest first in a queue;
  // each accepted request appends exactly one expected result.
  // ---------------------------------------------------------------------------
  class dedup_fifo_shadow;
    logic [ENTRY_W-1:0] held_pkts[$];
    logic [LIM_W-1:0]   limit_reg;
    rsp_t               owed_results[$];
    int                 errors;

    function new();
      limit_reg = LIMIT_RESET;
      errors    = 0;
    endfunction

    function void set_limit(logic [LIM_W-1:0] v);
      limit_reg = v;
    endfunction

    function int pending();
      return owed_results.size();
    endfunction

    function void note_error(string msg);
      errors++;
      if (errors <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
    endfunction

    // Work out the result of one accepted request and update the shadow state.
    function void note_request(req_t r);
      rsp_t               e;
      logic [ENTRY_W-1:0] w;
      bit                 dup;
      int                 lim;
      int                 n;
      e = '0;
      case (cmd_t'(r.cmd))
        CMD_ADD: begin
          w   = {r.src_id, r.dest_id, r.stamp};
          dup = 1'b0;
          foreach (held_pkts[i]) if (held_pkts[i] == w) dup = 1'b1;
          if (!dup) begin
            e.accepted = 1'b1;
            lim = int'(limit_reg);
            if (lim == 0) lim = 1;
            if (lim > CAPACITY) lim = CAPACITY;
            // only one eviction per add, even if the limit was lowered
            if (held_pkts.size() >= lim) begin
              held_pkts.delete(0);
              e.dropped_oldest = 1'b1;
            end
            held_pkts = {held_pkts, w};
          end
        end
        CMD_FWD: begin
          if (held_pkts.size() > 0) begin
            w           = held_pkts[0];
            held_pkts.delete(0);
            e.fwd_valid = 1'b1;
            e.out_src   = w[63:48];
            e.out_dest  = w[47:32];
            e.out_stamp = w[31:0];
          end
        end
        CMD_COUNT: begin
          n = 0;
          foreach (held_pkts[i])
            if (held_pkts[i][47:32] == r.dest_id && held_pkts[i][31:0] >= r.range_start &&
                held_pkts[i][31:0] <= r.range_end) n++;
          if (n > int'(CNT_MAX)) n = int'(CNT_MAX);
          e.match_count = CNT_W'(n);
        end
        default: ;
      endcase
      owed_results = {owed_results, e};
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got)
        note_error($sformatf("%s expected %0h, got %0h", name, want, got));
    endfunction

    // Compare one result transfer against the oldest expectation.
    function void check_result(rsp_t got);
      rsp_t e;
      if (owed_results.size() == 0) begin
        note_error($sformatf("result %0h with nothing expected", got));
        return;
      end
      e = owed_results[0];
      owed_results.delete(0);
      compare_field("accepted", e.accepted, got.accepted);
      compare_field("dropped_oldest", e.dropped_oldest, got.dropped_oldest);
      compare_field("fwd_valid", e.fwd_valid, got.fwd_valid);
      compare_field("out_src", e.out_src, got.out_src);
      compare_field("out_dest", e.out_dest, got.out_dest);
      compare_field("out_stamp", e.out_stamp, got.out_stamp);
      compare_field("match_count", e.match_count, got.match_count);
    endfunction

    // Anything still owed at the end is a failure.
    function void check_leftover();
      if (owed_results.size() != 0)
        note_error($sformatf("%0d results never arrived", owed_results.size()));
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // Signals and DUT
  // ---------------------------------------------------------------------------
  logic             clk = 1'b0;
  logic             rst;
  logic             req_valid;
  logic             req_ready;
  req_t             req;
  logic             rsp_valid;
  logic             rsp_ready = 1'b0;
  rsp_t             rsp;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [LIM_W-1:0] cfg_data;

  dedup_fifo_shadow   board;
  logic [ENTRY_W-1:0] recent_adds[$];   // recent add triples, reused to provoke duplicates
  bit                 req_idle_en;
  bit                 rsp_idle_en;
  int                 cycles = 0;
  int                 rsp_stall = 0;

  dedup_packet_fifo_with_range_count_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  // Watchdog: a hung handshake ends the run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > MAX_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Gap length: mostly none, some short, a few long.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Result side back-pressure, changed at the falling edge.
  always @(negedge clk) begin
    if (rsp_stall > 0) begin
      rsp_ready <= 1'b0;
      rsp_stall--;
    end else if (rsp_idle_en && $urandom_range(0, 3) == 0) begin
      rsp_ready <= 1'b0;
      rsp_stall = pick_gap();
    end else begin
      rsp_ready <= 1'b1;
    end
  end

  // Every result transfer is checked at the rising edge.
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) board.check_result(rsp);
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // IDs lean toward a tiny pool so adds collide and counts find matches.
  function automatic logic [15:0] rand_id();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2, 3:    return 16'($urandom);
      default: return 16'($urandom_range(0, 3));
    endcase
  endfunction

  function automatic logic [31:0] rand_stamp();
    case ($urandom_range(0, 9))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2, 3:    return $urandom;
      4:       return 32'hFFFF_FFF0 + 32'($urandom_range(0, 15));
      default: return 32'($urandom_range(0, 15));
    endcase
  endfunction

  function automatic req_t mk_req(cmd_t c, logic [15:0] s, logic [15:0] d, logic [31:0] t,
                                  logic [31:0] lo, logic [31:0] hi);
    req_t r;
    r.cmd         = c;
    r.src_id      = s;
    r.dest_id     = d;
    r.stamp       = t;
    r.range_start = lo;
    r.range_end   = hi;
    return r;
  endfunction

  // Random request; add_pct sets the add share, the rest splits forward/count/unused (rolls 97-99).
  function automatic req_t make_req(int add_pct);
    req_t               r;
    int                 roll;
    logic [ENTRY_W-1:0] pick;
    r = mk_req(CMD_NONE, rand_id(), rand_id(), rand_stamp(), rand_stamp(), rand_stamp());
    roll = $urandom_range(0, 99);
    if (roll < add_pct) begin
      r.cmd = CMD_ADD;
      if (recent_adds.size() > 0 && $urandom_range(0, 4) == 0) begin
        pick = recent_adds[$urandom_range(0, recent_adds.size() - 1)];
        {r.src_id, r.dest_id, r.stamp} = pick;
      end
      recent_adds = {recent_adds, {r.src_id, r.dest_id, r.stamp}};
      if (recent_adds.size() > 24) recent_adds.delete(0);
    end else if (roll < add_pct + (100 - add_pct) / 2) begin
      r.cmd = CMD_FWD;
    end else if (roll < 97) begin
      r.cmd = CMD_COUNT;
      if (recent_adds.size() > 0 && $urandom_range(0, 9) < 6)
        r.dest_id = recent_adds[$urandom_range(0, recent_adds.size() - 1)][47:32];
      if ($urandom_range(0, 4) == 0) begin
        r.range_start = 32'h0000_0000;
        r.range_end   = 32'hFFFF_FFFF;
      end
    end
    return r;
  endfunction

  // One request transfer. Valid is held high across back-to-back requests.
  task automatic send_request(input req_t r);
    int gap;
    gap = req_idle_en ? pick_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req       <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    board.note_request(r);
  endtask

  // Drop valid, let every owed result arrive, then allow the worst latency.
  task automatic wait_idle();
    @(negedge clk);
    req_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Config transfer; only called with the unit idle.
  task automatic write_limit(input logic [LIM_W-1:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    board.set_limit(v);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input logic [LIM_W-1:0] lim, input int n_items, input int add_pct,
                           input bit idle);
    write_limit(lim);
    req_idle_en = idle;
    rsp_idle_en = idle || ($urandom_range(0, 1) == 1);
    repeat (n_items) send_request(make_req(add_pct));
    wait_idle();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    board       = new();
    rst         = 1'b1;
    req_valid   = 1'b0;
    req         = '0;
    cfg_valid   = 1'b0;
    cfg_data    = '0;
    req_idle_en = 1'b0;
    rsp_idle_en = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part at the reset limit, no idling.
    send_request(mk_req(CMD_FWD, 16'h1234, 16'h5678, 32'h1, 32'h0, 32'hFFFF_FFFF));  // empty
    send_request(mk_req(CMD_COUNT, 16'h0, 16'h0, 32'h0, 32'h0, 32'hFFFF_FFFF));      // empty
    send_request(mk_req(CMD_ADD, 16'h0000, 16'h0000, 32'h0000_0000, 32'h0, 32'h0));
    send_request(mk_req(CMD_ADD, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'h0, 32'h0));
    // duplicate of the oldest: rejected, nothing evicted
    send_request(mk_req(CMD_ADD, 16'h0000, 16'h0000, 32'h0000_0000, 32'h0, 32'h0));
    send_request(mk_req(CMD_ADD, 16'h0001, 16'h0000, 32'h0000_0005, 32'h0, 32'h0));
    send_request(mk_req(CMD_ADD, 16'h0000, 16'h0000, 32'h0000_0001, 32'h0, 32'h0));
    send_request(mk_req(CMD_ADD, 16'h0000, 16'h0001, 32'h0000_0000, 32'h0, 32'h0));
    send_request(mk_req(CMD_ADD, 16'hA5A5, 16'h5A5A, 32'hAAAA_5555, 32'h0, 32'h0));
    send_request(mk_req(CMD_ADD, 16'h5A5A, 16'hA5A5, 32'h5555_AAAA, 32'h0, 32'h0));
    // duplicate of a newer entry
    send_request(mk_req(CMD_ADD, 16'hA5A5, 16'h5A5A, 32'hAAAA_5555, 32'h0, 32'h0));
    send_request(mk_req(CMD_COUNT, 16'h0, 16'h0000, 32'h0, 32'h0000_0000, 32'hFFFF_FFFF));
    send_request(mk_req(CMD_COUNT, 16'h0, 16'h0000, 32'h0, 32'h0000_0001, 32'h0000_0005));
    // empty range: start above end
    send_request(mk_req(CMD_COUNT, 16'h0, 16'h0000, 32'h0, 32'h0000_0005, 32'h0000_0001));
    send_request(mk_req(CMD_COUNT, 16'h0, 16'hFFFF, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_request(mk_req(CMD_COUNT, 16'hFFFF, 16'h5A5A, 32'hFFFF_FFFF, 32'hAAAA_5555,
                        32'hAAAA_5555));
    // unused command, every field all ones
    send_request(mk_req(CMD_NONE, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                        32'hFFFF_FFFF));
    send_request(mk_req(CMD_FWD, 16'h0, 16'h0, 32'h0, 32'h0, 32'h0));
    // the forwarded packet is gone, so the same triple is accepted again
    send_request(mk_req(CMD_ADD, 16'h0000, 16'h0000, 32'h0000_0000, 32'h0, 32'h0));
    send_request(mk_req(CMD_FWD, 16'h0, 16'h0, 32'h0, 32'h0, 32'h0));
    send_request(mk_req(CMD_COUNT, 16'h0, 16'h0000, 32'h0, 32'h0000_0000, 32'hFFFF_FFFF));
    wait_idle();

    // Random phases: limit above capacity fills the store, then the limit is
    // lowered under a full store, then zero, one, two, the maximum and a random one.
    run_phase(7'd127, 150, 70, 1'b1);
    run_phase(7'd5,   100, 50, 1'b0);
    run_phase(7'd0,    80, 55, 1'b1);
    run_phase(7'd1,    80, 50, 1'b1);
    run_phase(7'd2,   100, 55, 1'b0);
    run_phase(7'd64,  150, 65, 1'b1);
    run_phase(LIM_W'($urandom_range(3, 63)), 140, 55, 1'b1);

    board.check_leftover();
    if (board.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: dedup_packet_fifo_with_range_count_unit.f
rtl/dpfrc_pkg.sv
rtl/dpfrc_ram.sv
rtl/dpfrc_scan.sv
rtl/dedup_packet_fifo_with_range_count_unit.sv
verif/tb_dedup_packet_fifo_with_range_count_unit.sv
